[hw/rtl/qjet_pkg.sv]
package qjet_pkg;

  localparam logic [1:0] CFG_C_REAL = 2'd0;
  localparam logic [1:0] CFG_C_IMAG = 2'd1;
  localparam logic [1:0] CFG_MAX_ITER = 2'd2;

  localparam logic [31:0] C_REAL_RST = 32'hFF00_0000;
  localparam logic [31:0] C_IMAG_RST = 32'h0000_0000;
  localparam int unsigned MAX_ITER_RST = 100;

  localparam logic signed [63:0] SMAX64 = 64'sd2147483647;
  localparam logic signed [63:0] SMIN64 = -64'sd2147483648;

  function automatic logic signed [63:0] sx64(input logic [31:0] v);
    return $signed({{32{v[31]}}, v});
  endfunction

  // Saturate to the 32-bit range; the top bit of the result flags saturation.
  function automatic logic [32:0] sat32(input logic signed [63:0] v);
    logic [32:0] r;
    if (v > SMAX64) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < SMIN64) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  // Saturate to the 32-bit range without a flag.
  function automatic logic [31:0] clip32(input logic signed [63:0] v);
    logic [32:0] r;
    r = sat32(v);
    return r[31:0];
  endfunction

  // Saturate symmetrically to +-(2^31-1).
  function automatic logic [31:0] sym32(input logic signed [63:0] v);
    logic [31:0] r;
    if (v > SMAX64) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -SMAX64) begin
      r = 32'h8000_0001;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[hw/rtl/quartic_julia_escape_time.sv]
// Escape-time counter for the quartic map x -> x^2((a+2) + (-1-2a)x + a x^2) in signed
// fixed point with FRAC_BITS fraction bits. A transfer starts when start_i is high while
// busy_o is low; busy_o stays high until the result is shown on the result ports for one
// cycle with done_o, and the receiver must take it then. Every point first derives a from
// c on the shared 32x32 multiplier, then runs two bit-serial divisions (none when the
// bracket is zero) and a setup state, followed by the map iterations on the multiplier.
// A new point is taken only once busy_o is low again, after the last result. Configuration
// writes are taken in any cycle and must only be made while busy_o is low.
module quartic_julia_escape_time
  import qjet_pkg::*;
#(
  parameter int FRAC_BITS = 24,
  parameter int COUNT_WIDTH = 10
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic signed [31:0]     z_real_i,
  input  logic signed [31:0]     z_imag_i,
  output logic                   done_o,
  output logic                   inside_res_o,
  output logic [COUNT_WIDTH-1:0] iteration_count_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [1:0]             cfg_index_i,
  input  logic [31:0]            cfg_data_i
);

  localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic [63:0] LIMIT = 64'd100 << (2 * FRAC_BITS);
  localparam int DIV_STEPS = 64 + FRAC_BITS;
  localparam int DCW = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {ST_IDLE, ST_COEF, ST_DIV, ST_KSET, ST_ITER} state_e;

  state_e state_q;
  logic [4:0] step_q;
  logic signed [31:0] cr_q, ci_q;
  logic [COUNT_WIDTH-1:0] lim_q, it_q;
  logic signed [31:0] xr_q, xi_q, tr_q, ti_q, sr_q, si_q;
  logic signed [31:0] ar_q, ai_q, k0r_q, k1r_q, k1i_q;
  logic signed [31:0] nr_q, ni_q, dr_q, di_q;
  logic signed [63:0] acc_q, prod_q, numr_q, numi_q;
  logic [63:0] den_q, div_num_q, div_rem_q;
  logic [31:0] div_quo_q;
  logic div_ovf_q, div_neg_q, div_sel_q;
  logic [DCW-1:0] div_cnt_q;
  logic sat_q, done_q, inside_q;
  logic [COUNT_WIDTH-1:0] count_q;

  logic signed [31:0] op_a, op_b;
  logic signed [63:0] mr, sum, ksum;
  logic signed [31:0] kadd;
  logic neg;
  logic [32:0] c1, c2;
  logic [63:0] nrm;
  logic bit_in, ge, ovf_n;
  logic [64:0] rem_sh, rem_sub;
  logic [31:0] quo_n, mag, div_res;
  logic [15:0] lim_ext;

  assign busy_o = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign done_o = done_q;
  assign inside_res_o = inside_q;
  assign iteration_count_o = count_q;
  assign lim_ext = {6'd0, cfg_data_i[9:0]};

  always_comb begin
    op_a = xr_q;
    op_b = xr_q;
    if (state_q == ST_COEF) begin
      case (step_q)
        5'd0: begin op_a = cr_q; op_b = cr_q; end
        5'd1: begin op_a = ci_q; op_b = ci_q; end
        5'd2: begin op_a = cr_q; op_b = ci_q; end
        5'd4: begin op_a = dr_q; op_b = dr_q; end
        5'd5: begin op_a = di_q; op_b = di_q; end
        5'd6: begin op_a = nr_q; op_b = dr_q; end
        5'd7: begin op_a = ni_q; op_b = di_q; end
        5'd8: begin op_a = ni_q; op_b = dr_q; end
        5'd9: begin op_a = nr_q; op_b = di_q; end
        default: begin op_a = cr_q; op_b = cr_q; end
      endcase
    end else begin
      case (step_q)
        5'd0: begin op_a = xr_q; op_b = xr_q; end
        5'd1: begin op_a = xi_q; op_b = xi_q; end
        5'd2: begin op_a = ar_q; op_b = xr_q; end
        5'd3: begin op_a = ai_q; op_b = xi_q; end
        5'd4: begin op_a = ar_q; op_b = xi_q; end
        5'd5: begin op_a = ai_q; op_b = xr_q; end
        5'd6: begin op_a = tr_q; op_b = xr_q; end
        5'd7: begin op_a = ti_q; op_b = xi_q; end
        5'd8: begin op_a = tr_q; op_b = xi_q; end
        5'd9: begin op_a = ti_q; op_b = xr_q; end
        5'd10: begin op_a = xr_q; op_b = xr_q; end
        5'd11: begin op_a = xi_q; op_b = xi_q; end
        5'd12: begin op_a = xr_q; op_b = xi_q; end
        5'd13: begin op_a = xi_q; op_b = xr_q; end
        5'd14: begin op_a = sr_q; op_b = tr_q; end
        5'd15: begin op_a = si_q; op_b = ti_q; end
        5'd16: begin op_a = sr_q; op_b = ti_q; end
        5'd17: begin op_a = si_q; op_b = tr_q; end
        default: begin op_a = xr_q; op_b = xr_q; end
      endcase
    end
  end

  always_comb begin
    mr = (prod_q + HALF) >>> FRAC_BITS;
    neg = (step_q == 5'd4) || (step_q == 5'd8) || (step_q == 5'd12) || (step_q == 5'd16);
    case (step_q)
      5'd4: kadd = k1r_q;
      5'd6: kadd = k1i_q;
      5'd8: kadd = k0r_q;
      5'd10: kadd = ai_q;
      default: kadd = 32'sd0;
    endcase
    sum = neg ? (acc_q - mr) : (acc_q + mr);
    c1 = sat32(sum);
    ksum = sx64(c1[31:0]) + sx64(kadd);
    c2 = sat32(ksum);
    nrm = acc_q + prod_q;
  end

  always_comb begin
    bit_in = (div_cnt_q < DCW'(64)) ? div_num_q[63] : 1'b0;
    rem_sh = {div_rem_q, bit_in};
    ge = (rem_sh >= {1'b0, den_q});
    rem_sub = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
    quo_n = {div_quo_q[30:0], ge};
    ovf_n = div_ovf_q | div_quo_q[31];
    mag = (ovf_n || quo_n[31]) ? 32'h7FFF_FFFF : quo_n;
    div_res = div_neg_q ? (32'd0 - mag) : mag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q <= '0;
      cr_q <= C_REAL_RST;
      ci_q <= C_IMAG_RST;
      lim_q <= COUNT_WIDTH'(MAX_ITER_RST);
      it_q <= '0;
      xr_q <= '0; xi_q <= '0; tr_q <= '0; ti_q <= '0; sr_q <= '0; si_q <= '0;
      ar_q <= '0; ai_q <= '0; k0r_q <= '0; k1r_q <= '0; k1i_q <= '0;
      nr_q <= '0; ni_q <= '0; dr_q <= '0; di_q <= '0;
      acc_q <= '0; prod_q <= '0; numr_q <= '0; numi_q <= '0;
      den_q <= '0; div_num_q <= '0; div_rem_q <= '0; div_quo_q <= '0;
      div_ovf_q <= 1'b0; div_neg_q <= 1'b0; div_sel_q <= 1'b0; div_cnt_q <= '0;
      sat_q <= 1'b0; done_q <= 1'b0; inside_q <= 1'b0; count_q <= '0;
    end else begin
      prod_q <= op_a * op_b;
      done_q <= 1'b0;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_C_REAL: cr_q <= cfg_data_i;
          CFG_C_IMAG: ci_q <= cfg_data_i;
          CFG_MAX_ITER: lim_q <= lim_ext[COUNT_WIDTH-1:0];
          default: ;
        endcase
      end
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            xr_q <= z_real_i;
            xi_q <= z_imag_i;
            nr_q <= sym32((sx64(cr_q) <<< 1) + sx64(cr_q) - (ONE <<< 2));
            ni_q <= sym32((sx64(ci_q) <<< 1) + sx64(ci_q));
            sat_q <= 1'b0;
            it_q <= '0;
            step_q <= '0;
            state_q <= ST_COEF;
          end
        end
        ST_COEF: begin
          step_q <= step_q + 5'd1;
          case (step_q)
            5'd1: acc_q <= mr;
            5'd2: acc_q <= acc_q - mr;
            5'd3: begin
              dr_q <= sym32((acc_q <<< 1) - ((sx64(cr_q) <<< 1) + sx64(cr_q)) + ONE);
              di_q <= sym32((mr <<< 2) - ((sx64(ci_q) <<< 1) + sx64(ci_q)));
            end
            5'd5: acc_q <= prod_q;
            5'd6: den_q <= {nrm[62:0], 1'b0};
            5'd7: acc_q <= prod_q;
            5'd8: numr_q <= nrm;
            5'd9: acc_q <= prod_q;
            5'd10: begin
              numi_q <= acc_q - prod_q;
              step_q <= '0;
              if (den_q == 64'd0) begin
                ar_q <= 32'h7FFF_FFFF;
                ai_q <= 32'h7FFF_FFFF;
                state_q <= ST_KSET;
              end else begin
                div_num_q <= numr_q[63] ? (64'd0 - numr_q) : numr_q;
                div_neg_q <= numr_q[63];
                div_rem_q <= '0;
                div_quo_q <= '0;
                div_ovf_q <= 1'b0;
                div_cnt_q <= '0;
                div_sel_q <= 1'b0;
                state_q <= ST_DIV;
              end
            end
            default: ;
          endcase
        end
        ST_DIV: begin
          div_num_q <= {div_num_q[62:0], 1'b0};
          div_rem_q <= rem_sub[63:0];
          div_quo_q <= quo_n;
          div_ovf_q <= ovf_n;
          div_cnt_q <= div_cnt_q + DCW'(1);
          if (div_cnt_q == DCW'(DIV_STEPS - 1)) begin
            div_rem_q <= '0;
            div_quo_q <= '0;
            div_ovf_q <= 1'b0;
            div_cnt_q <= '0;
            if (!div_sel_q) begin
              ar_q <= div_res;
              div_num_q <= numi_q[63] ? (64'd0 - numi_q) : numi_q;
              div_neg_q <= numi_q[63];
              div_sel_q <= 1'b1;
            end else begin
              ai_q <= div_res;
              state_q <= ST_KSET;
            end
          end
        end
        ST_KSET: begin
          k0r_q <= clip32(sx64(ar_q) + (ONE <<< 1));
          k1r_q <= clip32(-ONE - (sx64(ar_q) <<< 1));
          k1i_q <= clip32(-(sx64(ai_q) <<< 1));
          step_q <= '0;
          state_q <= ST_ITER;
        end
        ST_ITER: begin
          step_q <= step_q + 5'd1;
          case (step_q)
            5'd0: begin
              if (it_q >= lim_q) begin
                done_q <= 1'b1;
                inside_q <= 1'b1;
                count_q <= '0;
                state_q <= ST_IDLE;
              end else if (sat_q) begin
                done_q <= 1'b1;
                inside_q <= 1'b0;
                count_q <= it_q;
                state_q <= ST_IDLE;
              end
            end
            5'd1: acc_q <= prod_q;
            5'd2: begin
              if (nrm >= LIMIT) begin
                done_q <= 1'b1;
                inside_q <= 1'b0;
                count_q <= it_q;
                state_q <= ST_IDLE;
              end
            end
            5'd3, 5'd5, 5'd7, 5'd9, 5'd11, 5'd13, 5'd15, 5'd17: acc_q <= mr;
            5'd4: begin tr_q <= c2[31:0]; sat_q <= sat_q | c1[32] | c2[32]; end
            5'd6: begin ti_q <= c2[31:0]; sat_q <= sat_q | c1[32] | c2[32]; end
            5'd8: begin tr_q <= c2[31:0]; sat_q <= sat_q | c1[32] | c2[32]; end
            5'd10: begin ti_q <= c2[31:0]; sat_q <= sat_q | c1[32] | c2[32]; end
            5'd12: begin sr_q <= c1[31:0]; sat_q <= sat_q | c1[32]; end
            5'd14: begin si_q <= c1[31:0]; sat_q <= sat_q | c1[32]; end
            5'd16: begin xr_q <= c1[31:0]; sat_q <= sat_q | c1[32]; end
            5'd18: begin
              xi_q <= c1[31:0];
              sat_q <= sat_q | c1[32];
              it_q <= it_q + COUNT_WIDTH'(1);
              step_q <= '0;
            end
            default: ;
          endcase
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("Result strobe lasted more than one cycle.");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("Accepted transfer did not raise busy.");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy_o)
    else $error("Result shown while still busy.");
  a_inside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && inside_res_o) |-> (iteration_count_o == '0))
    else $error("Inside result carries a nonzero count.");

endmodule
